// ===== rtl/core/chm_pkg.sv =====
// Shared types and constants of the chained hash map.
`timescale 1ns / 1ps
package chm_pkg;
	localparam int BUCKETS  = 64;
	localparam int CAPACITY = 256;
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(CAPACITY);
	localparam int PW = EW + 1;
	localparam logic [PW-1:0] NO_ENTRY = PW'(CAPACITY);
	localparam logic [31:0] HASH_MUL = 32'h61C88647;

	typedef enum logic [1:0] {OP_ADD = 2'd0, OP_GET = 2'd1, OP_REMOVE = 2'd2, OP_NONE = 2'd3}
		op_t;
	typedef enum logic [1:0] {ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2,
		ST_ZERO = 2'd3} status_t;

	typedef struct packed {
		op_t          op;
		logic [63:0]  key;
		logic [63:0]  value;
		logic [BW-1:0] bucket;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_HEAD, BK_READ, BK_CHECK, BK_FREE, BK_DONE, BK_CLEAR
	} bk_state_t;
endpackage

// ===== rtl/core/chm_front.sv =====
// Front end: hashes the key, picks the bucket, and holds a short command queue.
`timescale 1ns / 1ps
module chm_front import chm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  bucket_bits,
	input  logic        flush,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_op,
	input  logic [63:0] in_key,
	input  logic [63:0] in_value,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	// Stage 1 registers the product so the multiply stands alone.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [63:0] key_s1, value_s1;
	logic [31:0] hash_s1;
	logic [31:0] mask;
	logic [31:0] masked;
	cmd_t        ent;
	cmd_t        fifo_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign in_ready = !valid_s1 || (cnt_q < 2'd2);
	assign push = valid_s1 && (cnt_q < 2'd2);
	assign pop  = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (flush) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= in_op;
			key_s1   <= in_key;
			value_s1 <= in_value;
			hash_s1  <= in_key[31:0] * HASH_MUL;
		end
	end

	assign mask   = (32'd1 << bucket_bits) - 32'd1;
	assign masked = hash_s1 & mask;
	always_comb begin
		ent.op     = op_t'(op_s1);
		ent.key    = key_s1;
		ent.value  = value_s1;
		ent.bucket = masked[BW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (flush) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= ent;
	end

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rp_q];
endmodule

// ===== rtl/core/chm_back.sv =====
// Back end: walks bucket chains in the entry pool and produces results.
`timescale 1ns / 1ps
module chm_back import chm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          flush,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cmd_t          cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output logic [1:0]    res_status,
	output logic [63:0]   res_value,
	output logic [PW-1:0] res_count
);
	logic [PW-1:0] head_mem [BUCKETS];
	logic [BUCKETS-1:0] head_ok_q;
	logic [63:0]   key_mem  [CAPACITY];
	logic [63:0]   val_mem  [CAPACITY];
	logic [PW-1:0] next_mem [CAPACITY];
	logic [CAPACITY-1:0] used_q;

	bk_state_t state_q, state_d;
	cmd_t          c_q;
	logic [PW-1:0] cur_q, prev_q, head_rd_q;
	logic [PW:0]   steps_q;
	logic [63:0]   rk_q, rv_q;
	logic [PW-1:0] rn_q;
	logic [PW-1:0] free_q;
	logic [EW-1:0] scan_q;
	logic          free_ok_q;
	logic [PW-1:0] count_q;
	logic          rvalid_q;
	logic [1:0]    rstat_q;
	logic [63:0]   rval_q;
	logic [1:0]    ostat_q;
	logic [63:0]   oval_q;
	logic [PW-1:0] ocnt_q;
	logic          out_free;
	logic [PW-1:0] head_now;
	logic          hit;

	assign head_now = head_ok_q[c_q.bucket] ? head_rd_q : NO_ENTRY;
	assign hit = used_q[cur_q[EW-1:0]] && (rk_q == c_q.key);
	assign out_free = !rvalid_q || res_ready;
	assign cmd_ready = (state_q == BK_IDLE);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (cmd_valid) state_d = BK_HEAD;
			BK_HEAD: begin
				if (c_q.op == OP_ADD) state_d = BK_FREE;
				else state_d = BK_READ;
			end
			BK_READ:  state_d = BK_CHECK;
			BK_CHECK: begin
				if (c_q.op == OP_NONE) state_d = BK_DONE;
				else if (cur_q == NO_ENTRY || steps_q >= (PW+1)'(CAPACITY)) state_d = BK_DONE;
				else if (cur_q[PW-1]) state_d = BK_DONE;
				else if (hit) state_d = BK_DONE;
				else state_d = BK_READ;
			end
			BK_FREE:  if (free_ok_q || scan_q == EW'(CAPACITY-1)) state_d = BK_DONE;
			BK_DONE:  if (out_free) state_d = BK_IDLE;
			BK_CLEAR: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else if (flush) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// Datapath and pool updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ok_q <= '0;
			used_q    <= '0;
			count_q   <= '0;
			rvalid_q  <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (flush) begin
			head_ok_q <= '0;
			used_q    <= '0;
			count_q   <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			// The output register takes the finished result once it is free.
			if (state_q == BK_DONE && out_free) rvalid_q <= 1'b1;
			else if (res_ready) rvalid_q <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					free_ok_q <= 1'b0;
				end
				BK_HEAD: begin
					cur_q   <= head_now;
					prev_q  <= NO_ENTRY;
					steps_q <= '0;
					scan_q  <= '0;
					if (c_q.op == OP_NONE) begin
						rstat_q <= ST_OK;
					end
				end
				BK_READ: ;
				BK_CHECK: begin
					rval_q <= 64'd0;
					if (c_q.op == OP_NONE) begin
						rstat_q <= ST_OK;
					end else if (cur_q[PW-1] || steps_q >= (PW+1)'(CAPACITY)) begin
						rstat_q <= ST_NOT_FOUND;
					end else if (hit) begin
						rstat_q <= ST_OK;
						rval_q  <= rv_q;
						if (c_q.op == OP_REMOVE) begin
							used_q[cur_q[EW-1:0]] <= 1'b0;
							if (count_q != '0) count_q <= count_q - PW'(1);
						end
					end else begin
						prev_q  <= cur_q;
						cur_q   <= rn_q;
						steps_q <= steps_q + (PW+1)'(1);
					end
				end
				BK_FREE: begin
					if (c_q.value == 64'd0) begin
						free_ok_q <= 1'b1;
						rstat_q   <= ST_ZERO;
					end else if (!free_ok_q) begin
						if (!used_q[scan_q]) begin
							free_ok_q <= 1'b1;
							free_q    <= {1'b0, scan_q};
							rstat_q   <= ST_OK;
							used_q[scan_q] <= 1'b1;
							head_ok_q[c_q.bucket] <= 1'b1;
							count_q   <= count_q + PW'(1);
						end else if (scan_q == EW'(CAPACITY-1)) begin
							rstat_q <= ST_FULL;
						end else begin
							scan_q <= scan_q + EW'(1);
						end
					end
					rval_q <= 64'd0;
				end
				BK_DONE: ;
				BK_CLEAR: ;
				default: ;
			endcase
		end
	end

	// Command capture, output register and memory ports.
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && cmd_valid) begin
			c_q       <= cmd;
			head_rd_q <= head_mem[cmd.bucket];
		end
		if (state_q == BK_DONE && out_free) begin
			ostat_q <= rstat_q;
			oval_q  <= rval_q;
			ocnt_q  <= count_q;
		end
		if (state_q == BK_READ || state_q == BK_HEAD) begin
			rk_q <= key_mem[cur_q[EW-1:0]];
			rv_q <= val_mem[cur_q[EW-1:0]];
			rn_q <= next_mem[cur_q[EW-1:0]];
		end
		if (state_q == BK_FREE && c_q.value != 64'd0 && !free_ok_q && !used_q[scan_q]) begin
			key_mem[scan_q]  <= c_q.key;
			val_mem[scan_q]  <= c_q.value;
			next_mem[scan_q] <= head_now;
			head_mem[c_q.bucket] <= {1'b0, scan_q};
		end
		if (state_q == BK_CHECK && c_q.op == OP_REMOVE && !cur_q[PW-1] &&
				steps_q < (PW+1)'(CAPACITY) && hit) begin
			if (prev_q == NO_ENTRY) head_mem[c_q.bucket] <= rn_q;
			else next_mem[prev_q[EW-1:0]] <= rn_q;
		end
	end

	assign res_valid  = rvalid_q;
	assign res_status = ostat_q;
	assign res_value  = oval_q;
	assign res_count  = ocnt_q;
endmodule

// ===== rtl/core/chained_hash_map.sv =====
// Top level of the chained hash map.
// The map takes one beat per operation on the s_axis channel: tdata holds
// op, key and value, and one result beat leaves on m_axis with status,
// found value and the entry count after the operation. The front end hashes
// the key in one registered multiply stage and places the command in a
// two-deep queue; the back end walks the bucket chain in the entry pool.
// The result beat passes the multiply register, the queue, the back-end
// states idle, head, read, check and done, and the output register when
// the first chain entry decides a get or remove, or head, free and done when
// an add finds entry zero free. Each further chain link adds a read and a
// check, each used pool entry that an add scans past adds a free step, and
// the back end takes a new command only from idle, after the last is done.
// Reset empties all buckets and the pool at once through valid bits, with
// bucket_bits returning to 6. Writing bucket_bits empties the map likewise.
// While m_axis is stalled the back end parks its result in an output
// register, finishes the next command and waits, and the queue then fills
// before s_axis_tready falls.
`timescale 1ns / 1ps
module chained_hash_map import chm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op [1:0], key [65:2], value [129:66], zero fill to 136 bits
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status [1:0], found_value [65:2], entry_count [74:66], zero fill to 80
	output logic [79:0]  m_axis_tdata
);
	logic [2:0]  bucket_bits_q;
	logic        cmd_valid, cmd_ready;
	cmd_t        cmd;
	logic [1:0]  rs;
	logic [63:0] rv;
	logic [PW-1:0] rc;

	// A configuration write also flushes both halves, emptying the map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bucket_bits_q <= 3'd6;
		else if (cfg_we) bucket_bits_q <= cfg_wdata[2:0];
	end

	chm_front u_front (
		.clk, .arst_n,
		.bucket_bits (bucket_bits_q),
		.flush       (cfg_we),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_op       (s_axis_tdata[1:0]),
		.in_key      (s_axis_tdata[65:2]),
		.in_value    (s_axis_tdata[129:66]),
		.cmd_valid, .cmd_ready, .cmd
	);

	chm_back u_back (
		.clk, .arst_n,
		.flush      (cfg_we),
		.cmd_valid, .cmd_ready, .cmd,
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_status (rs),
		.res_value  (rv),
		.res_count  (rc)
	);

	assign m_axis_tdata = {5'd0, rc, rv, rs};
endmodule
